// File: hdl/sfb_pkg.sv
// shared types, constants and crc helper for the sensor frame builder
// no dependencies; imported by every module of the block
package sfb_pkg;

    // command codes carried on the input tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_WORD  = 1'b1;

    // job queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // frame constants
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  HDR_TYPE  = 8'h08;
    localparam logic [5:0]  LEN_BASE  = 6'd7;
    localparam logic [2:0]  HDR_LAST  = 3'd4;
    localparam logic [2:0]  WORD_LAST = 3'd1;
    localparam logic [2:0]  TRL_LAST  = 3'd5;

    // bytes added and words expected per mask bit, indexed by bit 0..7
    localparam logic [2:0] LEN_ADD [8] = '{3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd4, 3'd2};
    localparam logic [1:0] WORD_NEED [8] = '{2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd1};

    typedef enum logic {
        JOB_START,
        JOB_WORD
    } job_kind_t;

    // one queued job: start carries {length-1, mask}, word carries the word
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] data;
        logic        trailer;
        logic        finish;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        PH_JOB,
        PH_TRAIL,
        PH_PAD,
        PH_CRC
    } phase_t;

    // one crc-16 byte step, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // fixed trailer bytes
    function automatic logic [7:0] trailer_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h12;
            3'd1:    v = 8'h34;
            3'd2:    v = 8'h56;
            3'd3:    v = 8'h78;
            3'd4:    v = 8'h9A;
            default: v = 8'hBC;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/sfb_front.sv
// front end: accepts input beats, tracks the open frame and queues jobs
// depends on sfb_pkg
module sfb_front
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    input  logic [7:0]  in_mask,
    input  logic [15:0] in_word,
    input  q_stat_t     q_stat,
    output logic        q_push,
    output job_t        q_job
);

    logic       open_reg, open_next;
    logic [3:0] rem_reg, rem_next;
    logic [5:0] len;
    logic [3:0] words;
    logic       accept;

    // frame length and word count from the mask
    always_comb
    begin
        len   = LEN_BASE;
        words = 4'd0;
        for (int b = 0; b < 8; b++)
        begin
            if (in_mask[b])
            begin
                len   = len + 6'(LEN_ADD[b]);
                words = words + 4'(WORD_NEED[b]);
            end
        end
    end

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // classify the beat, drop words outside a frame
    always_comb
    begin
        open_next     = open_reg;
        rem_next      = rem_reg;
        q_push        = 1'b0;
        q_job.kind    = JOB_WORD;
        q_job.data    = in_word;
        q_job.trailer = 1'b0;
        q_job.finish  = (rem_reg == 4'd1);
        if (in_cmd == CMD_START)
        begin
            q_push        = accept;
            q_job.kind    = JOB_START;
            q_job.data    = {2'b00, len - 6'd1, in_mask};
            q_job.trailer = in_mask[0];
            q_job.finish  = (words == 4'd0);
            if (accept)
            begin
                rem_next  = words;
                open_next = (words != 4'd0);
            end
        end
        else if (open_reg && rem_reg != 4'd0)
        begin
            q_push = accept;
            if (accept)
            begin
                rem_next  = rem_reg - 4'd1;
                open_next = (rem_reg != 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= 4'd0;
        end
        else
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// File: hdl/sfb_queue.sv
// short job queue between front and back ends, head visible combinationally
// depends on sfb_pkg
module sfb_queue
    import sfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign head       = mem_reg[rd_reg];
    assign stat.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hdl/sfb_back.sv
// back end: serializes queued jobs into frame bytes and keeps the crc
// depends on sfb_pkg
module sfb_back
    import sfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  q_stat_t    q_stat,
    output logic       q_pop,
    output phase_t     phase,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    phase_t      ph_reg, ph_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        trail_reg, trail_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;

    logic        slot;
    logic        emit;
    logic [7:0]  byte_sel;
    logic [15:0] crc_base;
    logic [15:0] crc_zero;
    logic        is_start;
    logic        job_done;
    logic        trail_sel;

    assign slot      = !ov_reg || out_ready;
    assign is_start  = (head.kind == JOB_START);
    assign crc_base  = (is_start && idx_reg == 3'd0) ? CRC_INIT : crc_reg;
    assign crc_zero  = crc_byte(crc_reg, 8'h00);
    assign job_done  = is_start ? (idx_reg == HDR_LAST) : (idx_reg == WORD_LAST);
    assign trail_sel = is_start ? head.trailer : trail_reg;

    // byte of the current job
    always_comb
    begin
        if (is_start)
        begin
            case (idx_reg) inside
                3'd0, 3'd2: byte_sel = head.data[15:8];
                3'd1, 3'd3: byte_sel = HDR_TYPE;
                default:    byte_sel = head.data[7:0];
            endcase
        end
        else
            byte_sel = (idx_reg == 3'd0) ? head.data[15:8] : head.data[7:0];
    end

    // sequencer
    always_comb
    begin
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        trail_next = trail_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        unique case (ph_reg)
            PH_JOB:
            begin
                if (slot && !q_stat.empty)
                begin
                    emit     = 1'b1;
                    ob_next  = byte_sel;
                    ol_next  = 1'b0;
                    crc_next = crc_byte(crc_base, byte_sel);
                    idx_next = idx_reg + 3'd1;
                    if (is_start && idx_reg == 3'd0)
                        trail_next = head.trailer;
                    if (job_done)
                    begin
                        q_pop    = 1'b1;
                        idx_next = 3'd0;
                        if (head.finish)
                            ph_next = trail_sel ? PH_TRAIL : PH_PAD;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (slot)
                begin
                    emit     = 1'b1;
                    ob_next  = trailer_byte(idx_reg);
                    ol_next  = 1'b0;
                    crc_next = crc_byte(crc_reg, trailer_byte(idx_reg));
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == TRL_LAST)
                    begin
                        idx_next = 3'd0;
                        ph_next  = PH_PAD;
                    end
                end
            end
            PH_PAD:
            begin
                // first zero byte of the crc augmentation
                crc_next = crc_zero;
                ph_next  = PH_CRC;
            end
            PH_CRC:
            begin
                if (slot)
                begin
                    emit = 1'b1;
                    if (idx_reg == 3'd0)
                    begin
                        crc_next = crc_zero;
                        ob_next  = crc_zero[15:8];
                        ol_next  = 1'b0;
                        idx_next = 3'd1;
                    end
                    else
                    begin
                        ob_next  = crc_reg[7:0];
                        ol_next  = 1'b1;
                        idx_next = 3'd0;
                        ph_next  = PH_JOB;
                    end
                end
            end
            default: ph_next = PH_JOB;
        endcase
        if (emit)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_JOB;
            idx_reg   <= 3'd0;
            crc_reg   <= CRC_INIT;
            trail_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            trail_reg <= trail_next;
            ov_reg    <= ov_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    assign phase     = ph_reg;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

endmodule

// File: hdl/sensor_frame_builder_crc16.sv
// top level of the telemetry frame builder with crc-16 trailer
// depends on sfb_pkg, sfb_front, sfb_queue, sfb_back
//
//  channel  dir  tdata                                tuser         tlast
//  s_axis   in   [7:0] presence_mask, [23:8] word     command       -
//  m_axis   out  [7:0] out_byte                       -             end_of_frame
//
// one output byte per cycle from the back-end serializer while m_axis_tready is
// high and jobs are queued; a word beat gives 2 bytes, a start beat 5 header bytes,
// plus 0 or 6 trailer bytes, an idle pad step and 2 crc bytes when the frame closes.
// the four-entry job queue lets the input keep flowing while bytes drain.
// asynchronous active-low reset; no clearing pass after reset.
// m_axis_tready low stalls the serializer; s_axis_tready drops only when the queue is full.
module sensor_frame_builder_crc16
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] presence_mask, [23:8] sensor_word
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    job_t    q_job;
    job_t    q_head;
    phase_t  phase;

    sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_mask  (s_axis_tdata[7:0]),
        .in_word  (s_axis_tdata[23:8]),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    sfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    sfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .phase     (phase),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("job queue overflow");

    // queue never popped when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_stat.empty))
        else $error("job queue underflow");

    // the idle pad cycle always leads straight into the crc bytes
    a_pad_to_crc: assert property (@(posedge clk) disable iff (!rst_n)
        phase == PH_PAD |=> phase == PH_CRC)
        else $error("pad cycle not followed by crc");

    // last beat is only produced from the crc phase
    a_last_from_crc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid && m_axis_tlast) |-> $past(phase == PH_CRC))
        else $error("end of frame outside crc phase");
`endif

endmodule
